FILE: hdl/tsrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrf_pkg
// Shared types, sizes and helpers for the timing-frame receive framer.
// ----------------------------------------------------------------------------
package tsrf_pkg;

    localparam int RING_DEPTH = 64;
    localparam int SLOT_COUNT = 16;

    localparam int RING_AW = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
    localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int SEC_W   = 32;
    localparam int HM_W    = 11;
    localparam int BYTE_W  = 8;
    localparam int SIDX_W  = 4;

    // stream payload widths (packed fields, zero filled to whole bytes)
    localparam int S_DATA_W = 56;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 144;

    // configuration port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    typedef enum logic [1:0] {
        ACT_RX_BYTE = 2'd0,
        ACT_POP     = 2'd1,
        ACT_FLUSH   = 2'd2,
        ACT_SLOT_RD = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_MASTER_MODE = 2'd0,
        REG_HEADER_CODE = 2'd1,
        REG_SYNC_CODE   = 2'd2,
        REG_DELAY_CODE  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [SEC_W-1:0] sec;
        logic [HM_W-1:0]  hm;
    } t_stamp;

    // result fields held between the work stage and the output register
    typedef struct packed {
        logic   pop_hit;
        logic   avail;
        logic   pulse;
        t_stamp slot;
        t_stamp sync;
        t_stamp delay;
    } t_result;

    function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
        logic [RING_AW-1:0] q;
        if (p == RING_AW'(RING_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + RING_AW'(1);
        end
        return q;
    endfunction

endpackage

FILE: hdl/timesync_rx_framer_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timesync_rx_framer_ring
// Receive byte ring with header detection, time-stamp latch, master slot
// table and slave sync / delay-response capture.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                      | carries
//  ----------+-----------+--------------------------------+-------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | action, byte, clock
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | one result per item
//  apb       | in        | psel & penable & pwrite        | mode and codes
//
//  One transfer is taken per clock while s_axis_tready is high; a result
//  passes the work stage, then the output register. All state updates
//  happen at the accepting edge, so the next item sees them at once. The
//  ring read port is registered alongside the work stage.
//  Reset (i_rst_n low, synchronous) empties the ring and clears pointers,
//  flags, latched times and every slot. Ring contents are not cleared.
//  A stall on m_axis holds the output register; the work stage keeps one
//  more result, and s_axis_tready drops only when both are full.
// ----------------------------------------------------------------------------
module timesync_rx_framer_ring (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // s_axis_tdata: rx_byte[7:0], now_second[39:8], now_halfmillis[50:40],
    //               now_sign[51], slot_index[55:52]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [tsrf_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // s_axis_tuser: action[1:0]
    input  logic [tsrf_pkg::S_USER_W-1:0]   s_axis_tuser,

    // m_axis_tdata: read_byte[7:0], byte_available[8], sync_pulse[9],
    //               slot_second[41:10], slot_halfmillis[52:42],
    //               sync_time_second[84:53], sync_time_halfmillis[95:85],
    //               delay_time_second[127:96], delay_time_halfmillis[138:128],
    //               zero fill [143:139]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [tsrf_pkg::M_DATA_W-1:0]   m_axis_tdata,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsrf_pkg::CFG_AW-1:0]     paddr,
    input  logic [tsrf_pkg::CFG_DW-1:0]     pwdata,
    output logic [tsrf_pkg::CFG_DW-1:0]     prdata,
    output logic                            pready
);
    import tsrf_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        r_master_mode;
    logic [7:0]  r_header_code;
    logic [7:0]  r_sync_code;
    logic [7:0]  r_delay_code;
    logic        cfg_wr;
    t_cfg_reg    cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_sel = t_cfg_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_mode <= 1'b0;
            r_header_code <= 8'd0;
            r_sync_code   <= 8'd1;
            r_delay_code  <= 8'd2;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_MASTER_MODE: r_master_mode <= pwdata[0];
                REG_HEADER_CODE: r_header_code <= pwdata[7:0];
                REG_SYNC_CODE:   r_sync_code   <= pwdata[7:0];
                REG_DELAY_CODE:  r_delay_code  <= pwdata[7:0];
                default:         r_master_mode <= r_master_mode;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_MASTER_MODE: prdata = {31'd0, r_master_mode};
            REG_HEADER_CODE: prdata = {24'd0, r_header_code};
            REG_SYNC_CODE:   prdata = {24'd0, r_sync_code};
            REG_DELAY_CODE:  prdata = {24'd0, r_delay_code};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input field split
    // ------------------------------------------------------------------
    t_action            in_action;
    logic [7:0]         in_byte;
    t_stamp             in_now;
    logic [SIDX_W-1:0]  in_slot_idx;

    assign in_action   = t_action'(s_axis_tuser[1:0]);
    assign in_byte     = s_axis_tdata[7:0];
    assign in_now.sec  = s_axis_tdata[39:8];
    assign in_now.hm   = s_axis_tdata[50:40];
    // now_sign (bit 51) feeds no result and is not kept
    assign in_slot_idx = s_axis_tdata[55:52];

    // ------------------------------------------------------------------
    // Pipeline control: work stage (s1) and output register
    // ------------------------------------------------------------------
    logic     r_s1_valid;
    t_result  r_s1;
    logic     r_o_valid;
    logic [M_DATA_W-1:0] r_o_data;
    logic     s1_move;
    logic     accept;

    // s1 moves on when the output register is empty or being drained
    assign s1_move       = r_s1_valid & (~r_o_valid | m_axis_tready);
    assign s_axis_tready = ~r_s1_valid | ~r_o_valid | m_axis_tready;
    assign accept        = s_axis_tvalid & s_axis_tready;

    // ------------------------------------------------------------------
    // Framer state
    // ------------------------------------------------------------------
    logic [RING_AW-1:0] r_wpos, r_rpos;
    logic               r_await_ident;
    logic               r_type_armed;
    t_stamp             r_header_time;
    t_stamp             r_sync_time;
    t_stamp             r_delay_time;
    t_stamp             r_slot [SLOT_COUNT];
    logic [BYTE_W-1:0]  r_ring [RING_DEPTH];
    logic [BYTE_W-1:0]  r_rd_data;

    logic [RING_AW-1:0] n_wpos, n_rpos;
    logic               n_await_ident;
    logic               n_type_armed;
    t_stamp             n_header_time;
    t_stamp             n_sync_time;
    t_stamp             n_delay_time;
    logic               slot_we;
    logic [SLOT_AW-1:0] slot_wa;
    t_stamp             slot_wd;
    t_result            n_s1;

    logic               is_header;
    logic               id_in_range;
    logic               rd_in_range;
    logic               armed_eff;
    logic [7:0]         slot_idx8;

    assign is_header   = (in_byte == r_header_code);
    assign id_in_range = ({1'b0, in_byte} < 9'(SLOT_COUNT));
    assign slot_idx8   = {{(8 - SIDX_W){1'b0}}, in_slot_idx};
    assign rd_in_range = ({1'b0, slot_idx8} < 9'(SLOT_COUNT));
    // an identifier of zero arms the type check on this same byte
    assign armed_eff   = r_type_armed | (r_await_ident & (in_byte == 8'd0));

    always_comb begin
        n_wpos        = r_wpos;
        n_rpos        = r_rpos;
        n_await_ident = r_await_ident;
        n_type_armed  = r_type_armed;
        n_header_time = r_header_time;
        n_sync_time   = r_sync_time;
        n_delay_time  = r_delay_time;
        slot_we       = 1'b0;
        slot_wa       = '0;
        slot_wd       = r_header_time;
        n_s1          = '0;

        case (in_action)
            ACT_RX_BYTE: begin
                n_wpos = ring_next(r_wpos);
                if (is_header) begin
                    // header wins: latch time, re-arm identifier wait
                    n_s1.pulse    = 1'b1;
                    n_await_ident = 1'b1;
                    n_header_time = in_now;
                    if (r_master_mode) begin
                        slot_we = 1'b1;
                        slot_wa = '0;
                        slot_wd = in_now;
                    end
                end else if (r_master_mode) begin
                    if (r_await_ident) begin
                        n_await_ident = 1'b0;
                        n_type_armed  = 1'b1;
                        slot_we       = id_in_range;
                        slot_wa       = in_byte[SLOT_AW-1:0];
                    end
                end else begin
                    if (r_await_ident) begin
                        n_await_ident = 1'b0;
                        n_type_armed  = armed_eff;
                    end
                    if (armed_eff) begin
                        // delay response takes precedence when codes match
                        if (in_byte == r_delay_code) begin
                            n_delay_time = r_header_time;
                        end else if (in_byte == r_sync_code) begin
                            n_sync_time = r_header_time;
                        end
                    end
                end
            end
            ACT_POP: begin
                if (r_rpos != r_wpos) begin
                    n_s1.pop_hit = 1'b1;
                    n_rpos       = ring_next(r_rpos);
                end
            end
            ACT_FLUSH: begin
                n_rpos = r_wpos;
            end
            ACT_SLOT_RD: begin
                if (rd_in_range) begin
                    n_s1.slot = r_slot[slot_idx8[SLOT_AW-1:0]];
                end
            end
            default: begin
                n_rpos = r_rpos;
            end
        endcase

        n_s1.avail = (n_rpos != n_wpos);
        n_s1.sync  = n_sync_time;
        n_s1.delay = n_delay_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos        <= '0;
            r_rpos        <= '0;
            r_await_ident <= 1'b0;
            r_type_armed  <= 1'b0;
            r_header_time <= '0;
            r_sync_time   <= '0;
            r_delay_time  <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot[i] <= '0;
            end
        end else if (accept) begin
            r_wpos        <= n_wpos;
            r_rpos        <= n_rpos;
            r_await_ident <= n_await_ident;
            r_type_armed  <= n_type_armed;
            r_header_time <= n_header_time;
            r_sync_time   <= n_sync_time;
            r_delay_time  <= n_delay_time;
            if (slot_we) begin
                r_slot[slot_wa] <= slot_wd;
            end
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && (in_action == ACT_RX_BYTE)) begin
            r_ring[r_wpos] <= in_byte;
        end
    end

    // read data holds until the next pop, so a stalled s1 keeps its byte
    always_ff @(posedge i_clk) begin
        if (accept && (in_action == ACT_POP)) begin
            r_rd_data <= r_ring[r_rpos];
        end
    end

    // ------------------------------------------------------------------
    // Work stage and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_move) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_data <= {5'd0,
                         r_s1.delay.hm, r_s1.delay.sec,
                         r_s1.sync.hm,  r_s1.sync.sec,
                         r_s1.slot.hm,  r_s1.slot.sec,
                         r_s1.pulse, r_s1.avail,
                         (r_s1.pop_hit ? r_rd_data : 8'd0)};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

endmodule
